// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/c5k_pkg.sv =====
// Package: types and constants of the 5x5 multi-kernel convolution core
`timescale 1ns / 1ps
`default_nettype none
package c5k_pkg;
  localparam int IMAGE_SIZE_DEF   = 32;
  localparam int KERNEL_COUNT_DEF = 6;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int WIN  = 5;
  localparam int TAPS = 25;
  localparam int SUM_BITS = 36;
  localparam int PROD_BITS = 32;

  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [7:0]        weight_index;
    logic signed [15:0] sample;
    logic              frame_start;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         kernel_number;
    logic [4:0]         out_row;
    logic [4:0]         out_col;
    logic signed [35:0] conv_sum;
    logic               last;
    logic               frame_end;
  } out_req_t;

  // window tag latched by the closing pixel for the kernel passes of its window
  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic       image_end;
  } win_tag_t;
endpackage
`default_nettype wire

// ===== design/c5k_cell.sv =====
// Multiply-accumulate cell: one tap of the 25-tap chain
`timescale 1ns / 1ps
`default_nettype none
module c5k_cell (
  input  wire logic               clk,
  input  wire logic               advance,
  input  wire logic signed [15:0] pixel,
  input  wire logic signed [15:0] weight,
  input  wire logic signed [35:0] sum_in,
  output logic signed [35:0]      sum_out
);
  logic signed [31:0] prod;

  // register the product, then add on the next stage
  always_ff @(posedge clk) begin
    if (advance) begin
      prod    <= pixel * weight;
      sum_out <= sum_in + 36'(prod);
    end
  end
endmodule
`default_nettype wire

// ===== design/conv5x5_multi_kernel_stream_core.sv =====
// Top level: streaming valid 5x5 convolution with several stored kernels
`timescale 1ns / 1ps
`default_nettype none
// Streaming 5x5 valid convolution. Weight requests (mode 0) write the kernel
// store. Pixel requests (mode 1) arrive in raster order, and frame_start puts
// a pixel at (0,0). Each complete window yields KERNEL_COUNT results (6 by
// default), kernel 0 first, one per cycle while the output does not stall.
// A pixel that closes a window holds off the next request, because the input
// stalls until the last kernel pass starts. Pixels that close no window and
// weight requests cause no stall of their own. Five line buffers are read
// through a register (lrd) at the column of the next pixel, and each accepted
// pixel shifts one new column into a 5x5 window register. Each kernel pass
// then flows through a chain of 25 multiply-accumulate cells (two registers
// per cell). Tap t passes through t delay registers so that it meets the
// running sum. The result of a pass leaves the last cell, and a valid and tag
// line runs alongside the chain. Passes enter the chain back to back. A stall
// on a valid output freezes the whole chain and also stalls the input. Line
// buffers and kernel store come up undefined and need no clearing pass.
module conv5x5_multi_kernel_stream_core #(
  parameter int IMAGE_SIZE   = c5k_pkg::IMAGE_SIZE_DEF,
  parameter int KERNEL_COUNT = c5k_pkg::KERNEL_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire c5k_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output c5k_pkg::out_req_t     out_data
);
  localparam int WIN   = c5k_pkg::WIN;
  localparam int TAPS  = c5k_pkg::TAPS;
  localparam int DEPTH = KERNEL_COUNT * TAPS;
  localparam int CB    = $clog2(IMAGE_SIZE);
  localparam int KB    = (KERNEL_COUNT > 1) ? $clog2(KERNEL_COUNT) : 1;
  localparam int LAT   = TAPS + 1;

  // kernel store: one column of KERNEL_COUNT weights per tap, read at the
  // pass's kernel index by every tap at once
  logic signed [15:0] kstore [TAPS][KERNEL_COUNT];
  // five line buffers, each read at one column per cycle into lrd
  logic signed [15:0] lines [WIN][IMAGE_SIZE];
  logic signed [15:0] lrd [WIN];
  // 5x5 window, row-major, shifted left by one column per pixel
  logic signed [15:0] win [TAPS];

  logic [CB-1:0] col, row;
  logic [2:0]    line_sel;

  // sequencer of kernel passes for the latched window
  logic          busy;
  logic [KB-1:0] kidx;
  c5k_pkg::win_tag_t tag;

  function automatic logic [2:0] line_wrap(input logic [3:0] v);
    return (v >= 4'(WIN)) ? 3'(v - 4'(WIN)) : v[2:0];
  endfunction

  logic advance;
  assign advance = !out_stall || !out_valid;

  // take the next request at the edge of the last kernel pass
  logic last_pass;
  logic accept;
  assign last_pass = busy && (32'(kidx) == KERNEL_COUNT - 1);
  assign in_stall  = (busy && !last_pass) || !advance;
  assign accept    = in_valid && !in_stall;

  logic [CB-1:0] r_cur, c_cur;
  assign r_cur = (in_data.frame_start) ? '0 : row;
  assign c_cur = (in_data.frame_start) ? '0 : col;
  logic [2:0] ls_cur;
  assign ls_cur = (in_data.frame_start) ? 3'd0 : line_sel;

  logic pix, weight_wr, closes;
  assign pix       = accept && (in_data.mode == c5k_pkg::MODE_PIXEL);
  assign weight_wr = accept && (in_data.mode == c5k_pkg::MODE_WEIGHT)
                     && (32'(in_data.weight_index) < DEPTH);
  assign closes    = pix && (r_cur >= CB'(WIN - 1)) && (c_cur >= CB'(WIN - 1));

  // write weight: split index into kernel and tap by compare and subtract
  logic [7:0] wk, wt;
  always_comb begin
    wk = 8'd0;
    for (int k = 1; k < KERNEL_COUNT; k++) begin
      if (32'(in_data.weight_index) >= k * TAPS) wk = 8'(k);
    end
    wt = 8'(32'(in_data.weight_index) - 32'(wk) * TAPS);
  end

  // line buffer read address: the column of the next pixel
  logic [CB-1:0] rd_col;
  always_comb begin
    if (pix) begin
      rd_col = (32'(c_cur) == IMAGE_SIZE - 1) ? '0 : c_cur + 1'b1;
    end else begin
      rd_col = col;
    end
  end

  always_ff @(posedge clk) begin
    if (weight_wr) begin
      kstore[wt[4:0]][wk[KB-1:0]] <= in_data.sample;
    end
    if (pix) begin
      lines[ls_cur][c_cur] <= in_data.sample;
    end
    for (int x = 0; x < WIN; x++) begin
      lrd[x] <= lines[x][rd_col];
    end
  end

  // shift the window: oldest line on top, current pixel bottom right
  always_ff @(posedge clk) begin
    if (pix) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[i*WIN+j] <= win[i*WIN+j+1];
        end
        if (i == WIN - 1) begin
          win[i*WIN+WIN-1] <= in_data.sample;
        end else begin
          win[i*WIN+WIN-1] <= lrd[line_wrap(4'(ls_cur) + 4'(i + 1))];
        end
      end
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; line_sel <= 3'd0;
    end else if (pix) begin
      if (32'(c_cur) == IMAGE_SIZE - 1) begin
        col <= '0;
        if (32'(r_cur) == IMAGE_SIZE - 1) begin
          row <= '0; line_sel <= 3'd0;
        end else begin
          row <= r_cur + 1'b1;
          line_sel <= (ls_cur == 3'd4) ? 3'd0 : ls_cur + 3'd1;
        end
      end else begin
        col <= c_cur + 1'b1; row <= r_cur; line_sel <= ls_cur;
      end
    end
  end

  // pass sequencer: one kernel per advancing cycle
  logic pass_go;
  assign pass_go = busy && advance;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; kidx <= '0;
    end else if (closes) begin
      busy <= 1'b1; kidx <= '0;
    end else if (pass_go) begin
      if (32'(kidx) == KERNEL_COUNT - 1) busy <= 1'b0;
      kidx <= kidx + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (closes) begin
      tag.row <= 5'(r_cur - CB'(WIN - 1));
      tag.col <= 5'(c_cur - CB'(WIN - 1));
      tag.image_end <= (32'(r_cur) == IMAGE_SIZE - 1) && (32'(c_cur) == IMAGE_SIZE - 1);
    end
  end

  // cell t sees its tap through t delay registers, in step with the sum
  logic signed [15:0] pd [TAPS][TAPS];
  logic signed [15:0] wd [TAPS][TAPS];
  logic signed [35:0] chain [TAPS+1];
  assign chain[0] = '0;

  genvar t;
  generate
    for (t = 0; t < TAPS; t++) begin : g_tap
      if (t == 0) begin : g_head
        c5k_cell u_cell (
          .clk(clk), .advance(advance),
          .pixel(win[0]),
          .weight(kstore[0][kidx]),
          .sum_in(chain[0]), .sum_out(chain[1])
        );
      end else begin : g_skew
        always_ff @(posedge clk) begin
          if (advance) begin
            pd[t][0] <= win[t];
            wd[t][0] <= kstore[t][kidx];
            for (int d = 1; d < t; d++) begin
              pd[t][d] <= pd[t][d-1];
              wd[t][d] <= wd[t][d-1];
            end
          end
        end
        c5k_cell u_cell (
          .clk(clk), .advance(advance),
          .pixel(pd[t][t-1]),
          .weight(wd[t][t-1]),
          .sum_in(chain[t]), .sum_out(chain[t+1])
        );
      end
    end
  endgenerate

  // tag and valid line alongside the chain
  logic               vline [LAT];
  c5k_pkg::out_req_t  tline [LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < LAT; d++) vline[d] <= 1'b0;
    end else if (advance) begin
      vline[0] <= busy;
      for (int d = 1; d < LAT; d++) vline[d] <= vline[d-1];
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      tline[0].kernel_number <= 3'(kidx);
      tline[0].out_row   <= tag.row;
      tline[0].out_col   <= tag.col;
      tline[0].conv_sum  <= '0;
      tline[0].last      <= (32'(kidx) == KERNEL_COUNT - 1);
      tline[0].frame_end <= (32'(kidx) == KERNEL_COUNT - 1) && tag.image_end;
      for (int d = 1; d < LAT; d++) tline[d] <= tline[d-1];
    end
  end

  // chain[TAPS] holds the pass result in step with the end of the valid and tag line
  assign out_valid = vline[LAT-1];
  always_comb begin
    out_data = tline[LAT-1];
    out_data.conv_sum = chain[TAPS];
  end
endmodule
`default_nettype wire

// ===== design/c5k_checker.sv =====
// Port checker for the convolution core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module c5k_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire c5k_pkg::in_req_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire c5k_pkg::out_req_t out_data
);
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `ASSERT_IMPLIES(a_fend_last, clk, rst, out_valid && out_data.frame_end, out_data.last)
  `ASSERT_IMPLIES(a_kern_rng, clk, rst, out_valid, out_data.kernel_number < 3'd6)
  `ASSERT_IMPLIES(a_pos_rng, clk, rst, out_valid, out_data.out_row < 5'd28 && out_data.out_col < 5'd28)
endmodule
bind conv5x5_multi_kernel_stream_core c5k_checker u_chk (.*);
`default_nettype wire

// ===== tb/sv/conv5x5_multi_kernel_stream_checker.sv =====
// Checker: predicts convolution results from observed requests and compares them
`timescale 1ns / 1ps
`default_nettype none
module conv5x5_multi_kernel_stream_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire c5k_pkg::in_req_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire c5k_pkg::out_req_t out_data,
  output int                     fail_count,
  output int                     pending
);
  import c5k_pkg::*;

  localparam int IMG  = IMAGE_SIZE_DEF;
  localparam int NKER = KERNEL_COUNT_DEF;

  logic signed [15:0] weights [NKER*TAPS];
  logic signed [15:0] lines [WIN][IMG];
  int unsigned        cur_row, cur_col;
  out_req_t           expected_q [$];

  initial fail_count = 0;
  assign pending = expected_q.size();

  task automatic report_mismatch(input string what, input logic [35:0] got,
                                 input logic [35:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Apply one accepted request to the predicted state.
  task automatic predict_request(input in_req_t req);
    int unsigned r, c;
    logic signed [35:0] acc;
    out_req_t res;
    begin
      if (req.mode == MODE_WEIGHT) begin
        if (req.weight_index < NKER*TAPS) weights[req.weight_index] = req.sample;
      end else begin
        if (req.frame_start) begin
          cur_row = 0;
          cur_col = 0;
        end
        r = cur_row;
        c = cur_col;
        lines[r % WIN][c] = req.sample;
        if (r >= WIN-1 && c >= WIN-1) begin
          for (int k = 0; k < NKER; k++) begin
            acc = '0;
            for (int i = 0; i < WIN; i++)
              for (int j = 0; j < WIN; j++)
                acc += 36'(lines[(r+1+i) % WIN][c-(WIN-1)+j])
                       * 36'(weights[k*TAPS + i*WIN + j]);
            res.kernel_number = 3'(k);
            res.out_row       = 5'(r - (WIN-1));
            res.out_col       = 5'(c - (WIN-1));
            res.conv_sum      = acc;
            res.last          = (k == NKER-1);
            res.frame_end     = (k == NKER-1) && r == IMG-1 && c == IMG-1;
            expected_q.push_back(res);
          end
        end
        cur_col = c + 1;
        if (cur_col >= IMG) begin
          cur_col = 0;
          cur_row = (r + 1 >= IMG) ? 0 : r + 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_req_t want;
    if (rst) begin
      cur_row = 0;
      cur_col = 0;
    end else begin
      if (in_valid && !in_stall) predict_request(in_data);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data.conv_sum, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.kernel_number !== want.kernel_number)
            report_mismatch("kernel_number", out_data.kernel_number, want.kernel_number);
          if (out_data.out_row !== want.out_row)
            report_mismatch("out_row", out_data.out_row, want.out_row);
          if (out_data.out_col !== want.out_col)
            report_mismatch("out_col", out_data.out_col, want.out_col);
          if (out_data.conv_sum !== want.conv_sum)
            report_mismatch("conv_sum", out_data.conv_sum, want.conv_sum);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
          if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_data.frame_end, want.frame_end);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/conv5x5_multi_kernel_stream_core_test.sv =====
// Testbench top: stimulus, stall patterns and verdict for the convolution core
`timescale 1ns / 1ps
`default_nettype none
module conv5x5_multi_kernel_stream_core_test;
  import c5k_pkg::*;

  localparam int IMG      = IMAGE_SIZE_DEF;
  localparam int NKER     = KERNEL_COUNT_DEF;
  localparam int DRAIN    = 120;       // extra wait after the last expected result
  localparam int MAX_CYC  = 1_500_000; // far above the slowest legal run

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;
  int       fail_count, pending;
  int       cycle = 0;
  bit       long_hold = 1'b0;  // request a long receiver hold-off
  bit       hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  conv5x5_multi_kernel_stream_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  conv5x5_multi_kernel_stream_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Abort on runaway: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYC) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: draw a stall length per result; hold for a long stretch once
  // when asked so the core backs up and stalls its input.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Offer one request, hold it until accepted; optional gap before it.
  task automatic send_request(input in_req_t req, input bit may_idle);
    int n;
    n = may_idle ? $urandom_range(0, 9) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_weight(input int idx, input logic signed [15:0] w, input bit fs);
    in_req_t req;
    req.mode = MODE_WEIGHT;
    req.weight_index = 8'(idx);
    req.sample = w;
    req.frame_start = fs;
    send_request(req, 1'b0);
  endtask

  task automatic send_pixel(input logic signed [15:0] p, input bit fs, input bit may_idle);
    in_req_t req;
    req.mode = MODE_PIXEL;
    req.weight_index = 8'($urandom_range(0, 255));
    req.sample = p;
    req.frame_start = fs;
    send_request(req, may_idle);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int sent, pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every kernel weight once with extremes, so no unwritten entry is read.
    for (int i = 0; i < NKER*TAPS; i++)
      send_weight(i, (i % 2) ? 16'sh8000 : 16'sh7fff, i[0]);
    // Out-of-range indexes are ignored; cover the top of the index field.
    send_weight(150, 16'sh1234, 1'b0);
    send_weight(255, 16'sh5555, 1'b1);

    // Partial frame, then a frame restart mid-image.
    for (int i = 0; i < 40; i++)
      send_pixel(rand_sample(), i == 0, 1'b0);

    // Long receiver hold-off while five rows of extreme pixels keep coming.
    long_hold = 1'b1;
    for (int i = 0; i < 5*IMG; i++)
      send_pixel((i % 3 == 0) ? 16'sh8000 : 16'sh7fff, i == 0, 1'b0);
    while (!hold_done) @(posedge clk);
    wait_drained();

    // Random part: mostly in-order pixels, rare restarts and stray weights.
    sent = 0;
    while (sent < 30) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_pixel(rand_sample(), 1'b1, 1'b1);
      end else if (pick == 1) begin
        send_weight($urandom_range(150, 255), rand_sample(), $urandom_range(0, 1));
      end else begin
        send_pixel(rand_sample(), 1'b0, ($urandom_range(0, 3) != 0));
      end
      sent++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
